// ===== src/mhpq_pkg.sv =====
// Package for the min-heap priority queue: sizes, status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W    = IDX_W + 2;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

endpackage

// ===== src/mhpq_if.sv =====
// Request and response channel interfaces for the min-heap priority queue.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

interface mhpq_req_if import mhpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] result_value;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, status, result_value, count, input ready);
  modport sink   (input valid, status, result_value, count, output ready);
endinterface

// ===== src/min_heap_priority_queue.sv =====
// Bounded binary min-heap priority queue, heap held in one 2-read/1-write RAM.
// Depends on mhpq_pkg and the channel interfaces in mhpq_if.sv.
//
//   port    dir  contents
//   req_i   in   req_type (0 insert, 1 delete min), value
//   rsp_o   out  status, result_value, count
//
// An insert sifts up one level per read/compare pass; at the root it writes from S_UP_RD directly.
// A delete loads the root and the last element, then sifts down; no sift when it empties the heap.
// Each level is a RAM read state plus a compare/write state; that loop sets the rate.
// Refused requests go straight to the done state. One request is in flight at a time.
// rsp_o is registered; a stalled response holds the FSM in its done state.
// Reset clears the FSM state, the element count and the response valid; the heap RAM is not cleared.
`timescale 1ns / 1ps

module min_heap_priority_queue import mhpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mhpq_req_if.sink  req_i,
  mhpq_rsp_if.source rsp_o
);

  logic signed [VALUE_W-1:0] mem [HEAP_DEPTH];

  state_e                    state_q, state_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic signed [VALUE_W-1:0] cur_q, cur_d;
  logic signed [VALUE_W-1:0] res_q, res_d;
  status_e                   status_q, status_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic                      out_valid_q, out_valid_d;
  status_e                   out_status_q, out_status_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic [COUNT_W-1:0]        out_count_q, out_count_d;

  logic [IDX_W-1:0]          addr_a, addr_b, waddr, parent_idx;
  logic signed [VALUE_W-1:0] rd_a_q, rd_b_q, wdata;
  logic                      we;
  logic [CHILD_W-1:0]        left_idx, right_idx, cnt_ext;
  logic                      left_ok, right_ok, take_left, take_right;
  logic signed [VALUE_W-1:0] left_best;
  logic                      accept;

  assign accept     = req_i.valid && req_i.ready;
  assign parent_idx = (pos_q - IDX_W'(1)) >> 1;
  assign left_idx   = {CHILD_W'(pos_q) << 1} + CHILD_W'(1);
  assign right_idx  = left_idx + CHILD_W'(1);
  assign cnt_ext    = CHILD_W'(cnt_q);
  assign left_ok    = left_idx < cnt_ext;
  assign right_ok   = right_idx < cnt_ext;
  assign take_left  = left_ok && (rd_a_q < cur_q);
  assign left_best  = take_left ? rd_a_q : cur_q;
  assign take_right = right_ok && (rd_b_q < left_best);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    res_q        <= res_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    res_d        = res_q;
    status_d     = status_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    addr_a       = '0;
    addr_b       = IDX_W'(cnt_q - CNT_W'(1));
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = cur_q;
    req_i.ready  = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          if (req_i.req_type == REQ_INSERT) begin
            if (cnt_q == CNT_W'(HEAP_DEPTH)) begin
              status_d = ST_OVERFLOW;
              res_d    = '0;
              state_d  = S_DONE;
            end else begin
              status_d = ST_OK;
              res_d    = req_i.value;
              cur_d    = req_i.value;
              pos_d    = IDX_W'(cnt_q);
              cnt_d    = cnt_q + CNT_W'(1);
              state_d  = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_UNDERFLOW;
              res_d    = '0;
              state_d  = S_DONE;
            end else begin
              status_d = ST_OK;
              cnt_d    = cnt_q - CNT_W'(1);
              state_d  = S_DEL_LD;
            end
          end
        end
      end
      S_DEL_LD: begin
        res_d   = rd_a_q;
        cur_d   = rd_b_q;
        pos_d   = '0;
        state_d = (cnt_q == '0) ? S_DONE : S_DN_RD;
      end
      S_UP_RD: begin
        addr_a = parent_idx;
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cur_q < rd_a_q) begin
          wdata   = rd_a_q;
          pos_d   = parent_idx;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN_RD: begin
        addr_a  = left_idx[IDX_W-1:0];
        addr_b  = right_idx[IDX_W-1:0];
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (take_right) begin
          wdata   = rd_b_q;
          pos_d   = right_idx[IDX_W-1:0];
          state_d = S_DN_RD;
        end else if (take_left) begin
          wdata   = rd_a_q;
          pos_d   = left_idx[IDX_W-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = res_q;
          out_count_d  = COUNT_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.count        = out_count_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HEAP_DEPTH))
    else $error("element count above depth");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_CMP))
    else $error("heap write outside sift states");

  a_pos_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RD ||
     state_q == S_DN_CMP) |-> (CNT_W'(pos_q) < cnt_q))
    else $error("sift position outside live heap");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted item not processed");

  a_done_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !rsp_o.ready) |=> state_q == S_DONE)
    else $error("result dropped while output stalled");
`endif

endmodule
